// File: design/dhcpla_pkg.sv
package dhcpla_pkg;

  // Default pool depth and the width of one bitmap slice looked at per cycle.
  localparam int POOL_SIZE_DEF = 256;
  localparam int CHUNK_BITS    = 16;
  localparam int BIT_W         = $clog2(CHUNK_BITS);

  // Stream payload widths; the input data width is rounded up to whole bytes.
  localparam int IN_DATA_W  = 184;
  localparam int IN_USER_W  = 8;
  localparam int OUT_DATA_W = 112;
  localparam int OUT_USER_W = 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_PREFIX = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SERVER_ADDR = 8'd1;
  localparam logic [23:0] PREFIX_RESET = 24'hC0A800;

  // DHCP option 53 values that the server reacts to.
  localparam logic [7:0] MSG_DISCOVER = 8'd1;
  localparam logic [7:0] MSG_REQUEST  = 8'd3;

  localparam logic [31:0] ADDR_BCAST = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    KIND_NONE      = 2'd0,
    KIND_OFFER     = 2'd1,
    KIND_ACK       = 2'd2,
    KIND_EXHAUSTED = 2'd3
  } kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // latch the incoming item and classify it
    logic scan_step; // look at the current bitmap slice
    logic load_out;  // build the result into the output register
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic is_disc;   // incoming item is a valid DISCOVER
    logic scan_done; // current slice hit, or it was the last slice
  } stat_t;

endpackage

// File: design/dhcpla_ctrl.sv
module dhcpla_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  input  dhcpla_pkg::stat_t  stat,
  output dhcpla_pkg::cmd_t   cmd
);
  import dhcpla_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   out_valid_next;
  logic   out_free;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid || m_tready;

  // Sequencing of one item: accept, optional bitmap scan, result load.
  always_comb begin
    state_next    = state;
    cmd.accept    = 1'b0;
    cmd.scan_step = 1'b0;
    cmd.load_out  = 1'b0;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = stat.is_disc ? S_SCAN : S_EMIT;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output valid flag follows loads and takes.
  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;

`ifndef SYNTHESIS
  // A new result never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || m_tready))
    else $error("result loaded over an untaken result");

  // An item that needs no scan goes straight to the result stage.
  a_direct_emit: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && !stat.is_disc) |=> (state == S_EMIT))
    else $error("non-discover item did not go to result stage");

  // A finished scan always leads to a result load path.
  a_scan_exit: assert property (@(posedge clk) disable iff (rst)
    (cmd.scan_step && stat.scan_done) |=> (state == S_EMIT))
    else $error("scan finished but result stage not entered");
`endif

endmodule

// File: design/dhcpla_dp.sv
module dhcpla_dp #(
  parameter int POOL_SIZE = dhcpla_pkg::POOL_SIZE_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [dhcpla_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic [dhcpla_pkg::IN_USER_W-1:0]   s_tuser,
  input  logic                               cfg_valid,
  input  logic [dhcpla_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dhcpla_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic [dhcpla_pkg::OUT_DATA_W-1:0]  m_tdata,
  output logic [dhcpla_pkg::OUT_USER_W-1:0]  m_tuser,
  input  dhcpla_pkg::cmd_t                   cmd,
  output dhcpla_pkg::stat_t                  stat
);
  import dhcpla_pkg::*;

  localparam int NCHUNK = (POOL_SIZE + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int PAD_W  = CHUNK_BITS << CW;
  localparam int IDX_W  = CW + BIT_W;

  // Fields of the incoming item.
  logic        in_bcast;
  logic [31:0] in_client;
  logic [31:0] in_relay;
  logic [31:0] in_xid;
  logic [31:0] in_your;
  logic [47:0] in_mac;
  logic [7:0]  in_type;

  assign in_bcast  = s_tdata[0];
  assign in_client = s_tdata[32:1];
  assign in_relay  = s_tdata[64:33];
  assign in_xid    = s_tdata[96:65];
  assign in_your   = s_tdata[128:97];
  assign in_mac    = s_tdata[176:129];
  assign in_type   = s_tuser;

  logic [23:0]      pool_prefix;
  logic [31:0]      xid_seen;
  logic             disc_r;
  logic             req_r;
  logic [31:0]      your_r;
  logic [47:0]      mac_r;
  logic [PAD_W-1:0] free_pad;
  logic [PAD_W-1:0] init_mask;
  logic [CW-1:0]    ccnt;
  logic             found;
  logic [IDX_W-1:0] found_idx;
  logic [1:0]       out_kind;
  logic [31:0]      out_assigned;
  logic [31:0]      out_dest;
  logic [47:0]      out_mac;

  logic                  in_disc;
  logic                  in_req;
  logic [CHUNK_BITS-1:0] chunk;
  logic                  hit;
  logic [BIT_W-1:0]      hit_bit;
  logic [IDX_W-1:0]      scan_idx;

  // Message classification against the remembered transaction id.
  assign in_disc = in_bcast && (in_client == 32'd0) && (in_relay == 32'd0) &&
                   (in_xid != xid_seen) && (in_type == MSG_DISCOVER);
  assign in_req  = in_bcast && (in_xid == xid_seen) && (in_type == MSG_REQUEST);

  // Free pattern after reset: host indices 2 to POOL_SIZE-2; padding is never free.
  always_comb begin
    for (int i = 0; i < PAD_W; i++) begin
      init_mask[i] = (i >= 2) && (i <= POOL_SIZE - 2);
    end
  end

  // Lowest free bit of the current slice.
  assign chunk = free_pad[ccnt * CHUNK_BITS +: CHUNK_BITS];

  always_comb begin
    hit     = 1'b0;
    hit_bit = '0;
    for (int b = CHUNK_BITS - 1; b >= 0; b--) begin
      if (chunk[b]) begin
        hit     = 1'b1;
        hit_bit = BIT_W'(b);
      end
    end
  end

  assign scan_idx       = {ccnt, hit_bit};
  assign stat.is_disc   = in_disc;
  assign stat.scan_done = hit || (ccnt == {CW{1'b1}});

  // Configuration writes; the server address feeds no result field.
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_prefix <= PREFIX_RESET;
    end else if (cfg_valid && (cfg_index == REG_POOL_PREFIX)) begin
      pool_prefix <= cfg_data[23:0];
    end
  end

  // Item capture and transaction memory.
  always_ff @(posedge clk) begin
    if (rst) begin
      xid_seen <= 32'd0;
      disc_r   <= 1'b0;
      req_r    <= 1'b0;
    end else if (cmd.accept) begin
      disc_r <= in_disc;
      req_r  <= in_req;
      if (in_disc) begin
        xid_seen <= in_xid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      your_r <= in_your;
      mac_r  <= in_mac;
    end
  end

  // Bitmap scan, one slice per cycle; the first free index found is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      free_pad <= init_mask;
      ccnt     <= '0;
      found    <= 1'b0;
    end else if (cmd.accept) begin
      ccnt  <= '0;
      found <= 1'b0;
    end else if (cmd.scan_step) begin
      if (hit) begin
        found              <= 1'b1;
        free_pad[scan_idx] <= 1'b0;
      end else begin
        ccnt <= ccnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step && hit) begin
      found_idx <= scan_idx;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      if (disc_r && found) begin
        out_kind     <= KIND_OFFER;
        out_assigned <= {pool_prefix, 8'(found_idx)};
        out_dest     <= ADDR_BCAST;
        out_mac      <= mac_r;
      end else if (disc_r) begin
        out_kind     <= KIND_EXHAUSTED;
        out_assigned <= 32'd0;
        out_dest     <= 32'd0;
        out_mac      <= mac_r;
      end else if (req_r) begin
        out_kind     <= KIND_ACK;
        out_assigned <= your_r;
        out_dest     <= your_r;
        out_mac      <= mac_r;
      end else begin
        out_kind     <= KIND_NONE;
        out_assigned <= 32'd0;
        out_dest     <= 32'd0;
        out_mac      <= 48'd0;
      end
    end
  end

  assign m_tdata = {out_mac, out_dest, out_assigned};
  assign m_tuser = out_kind;

`ifndef SYNTHESIS
  // An index handed out is no longer free.
  a_taken_cleared: assert property (@(posedge clk) disable iff (rst)
    found |-> !free_pad[found_idx])
    else $error("offered index still marked free");

  // Indices outside the host range never become free.
  a_range_kept: assert property (@(posedge clk) disable iff (rst)
    (free_pad & ~init_mask) == '0)
    else $error("index outside host range marked free");

  // A DISCOVER always leaves its transaction id behind.
  a_xid_stored: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && in_disc) |=> (xid_seen == $past(in_xid)))
    else $error("discover transaction id not stored");
`endif

endmodule

// File: design/dhcp_server_lease_allocator_unit.sv
// Channel   Dir  Handshake            Payload
// s_        in   s_tvalid/s_tready    s_tdata: client message, s_tuser: message type
// m_        out  m_tvalid/m_tready    m_tdata: reply fields, m_tuser: reply kind
// cfg_      in   cfg_valid/cfg_ready  cfg_index, cfg_data: register write
//
// A DISCOVER is followed by a scan of the free bitmap, 16-bit slice by slice, until a
// free bit is found or the last slice has been looked at; every other item goes
// straight to the result stage. The next item is taken once the result is loaded.
// Reset is synchronous; it restores the free pool, transaction id and prefix.
// A result waiting in the output register does not block acceptance of the next item.
module dhcp_server_lease_allocator_unit #(
  parameter int POOL_SIZE = dhcpla_pkg::POOL_SIZE_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [0] broadcast_flag, [32:1] client_addr, [64:33] relay_addr,
  // [96:65] transaction_id, [128:97] your_addr, [176:129] client_mac
  input  logic [dhcpla_pkg::IN_DATA_W-1:0]   s_tdata,
  // [7:0] message_type
  input  logic [dhcpla_pkg::IN_USER_W-1:0]   s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [31:0] assigned_addr, [63:32] dest_addr, [111:64] dest_mac
  output logic [dhcpla_pkg::OUT_DATA_W-1:0]  m_tdata,
  // [1:0] reply_kind
  output logic [dhcpla_pkg::OUT_USER_W-1:0]  m_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dhcpla_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dhcpla_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import dhcpla_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Register writes are always taken.
  assign cfg_ready = 1'b1;

  dhcpla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dhcpla_dp #(
    .POOL_SIZE (POOL_SIZE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// File: tb/sv/dhcp_server_lease_allocator_unit_test.sv
`timescale 1ns / 100ps

// One decoded client message as it goes into the block.
typedef struct packed {
  logic        bcast;
  logic [31:0] client_addr;
  logic [31:0] relay_addr;
  logic [31:0] xid;
  logic [31:0] your_addr;
  logic [7:0]  mtype;
  logic [47:0] mac;
} dhcp_msg_t;

// One reply item as the block should produce it.
typedef struct packed {
  dhcpla_pkg::kind_t kind;
  logic [31:0]       assigned;
  logic [31:0]       dest;
  logic [47:0]       mac;
} dhcp_reply_t;

// Keeps its own copy of the lease pool and the registers, works out the reply
// for every accepted message and checks the replies in order.
class lease_scoreboard;
  localparam int POOL = dhcpla_pkg::POOL_SIZE_DEF;

  bit [POOL-1:0] free_map;
  logic [31:0]   xid_seen;
  logic [23:0]   prefix;
  logic [31:0]   server_ip;
  logic [31:0]   last_offer;
  dhcp_reply_t   reply_q[$];
  int            errors;

  function new();
    free_map = '0;
    for (int i = 2; i <= POOL - 2; i++) free_map[i] = 1'b1;
    xid_seen   = '0;
    prefix     = dhcpla_pkg::PREFIX_RESET;
    server_ip  = '0;
    last_offer = '0;
    errors     = 0;
  endfunction

  function void note_config(logic [7:0] idx, logic [31:0] value);
    case (idx)
      dhcpla_pkg::REG_POOL_PREFIX: prefix = value[23:0];
      dhcpla_pkg::REG_SERVER_ADDR: server_ip = value;
      default: ;
    endcase
  endfunction

  // Classify the message and derive the reply; a DISCOVER consumes the lowest
  // free index for good.
  function void note_message(dhcp_msg_t m);
    dhcp_reply_t r;
    int idx;
    r = '0;
    r.kind = dhcpla_pkg::KIND_NONE;
    if (m.bcast && m.client_addr == 0 && m.relay_addr == 0 && m.xid != xid_seen &&
        m.mtype == dhcpla_pkg::MSG_DISCOVER) begin
      xid_seen = m.xid;
      r.mac = m.mac;
      idx = 0;
      while (idx < POOL && !free_map[idx]) idx++;
      if (idx == POOL) begin
        r.kind = dhcpla_pkg::KIND_EXHAUSTED;
      end else begin
        free_map[idx] = 1'b0;
        r.kind = dhcpla_pkg::KIND_OFFER;
        r.assigned = {prefix, idx[7:0]};
        r.dest = dhcpla_pkg::ADDR_BCAST;
        last_offer = r.assigned;
      end
    end else if (m.bcast && m.xid == xid_seen && m.mtype == dhcpla_pkg::MSG_REQUEST) begin
      r.kind = dhcpla_pkg::KIND_ACK;
      r.assigned = m.your_addr;
      r.dest = m.your_addr;
      r.mac = m.mac;
    end
    reply_q.push_back(r);
  endfunction

  function void flag(string what, logic [63:0] want, logic [63:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
  endfunction

  function void check_reply(logic [1:0] kind_bits, logic [111:0] data);
    dhcp_reply_t want;
    if (reply_q.size() == 0) begin
      flag("unexpected reply item", '0, {kind_bits, data[61:0]});
      return;
    end
    want = reply_q.pop_front();
    if (kind_bits !== want.kind)
      flag("reply_kind", 64'(want.kind), 64'(kind_bits));
    if (data[31:0] !== want.assigned)
      flag("assigned_addr", 64'(want.assigned), 64'(data[31:0]));
    if (data[63:32] !== want.dest)
      flag("dest_addr", 64'(want.dest), 64'(data[63:32]));
    if (data[111:64] !== want.mac)
      flag("dest_mac", 64'(want.mac), 64'(data[111:64]));
  endfunction

  function int pending();
    return reply_q.size();
  endfunction
endclass

module dhcp_server_lease_allocator_unit_test;
  import dhcpla_pkg::*;

  localparam int WATCHDOG_CYCLES = 2000;
  localparam int TAIL_CYCLES     = 40;
  localparam int PHASES          = 4;
  localparam int ITEMS_PER_PHASE = 172;

  // Register indexes with no register behind them.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_IDX  = 8'hFF;

  // Option 53 values that get a reply of kind none.
  localparam logic [7:0] MSG_ABSENT   = 8'd0;
  localparam logic [7:0] MSG_OFFER    = 8'd2;
  localparam logic [7:0] MSG_TYPE_MAX = 8'hFF;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [IN_USER_W-1:0]  s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bit              stall_on = 1'b1;
  int unsigned     stall_left = 0;
  lease_scoreboard sb;

  dhcp_server_lease_allocator_unit uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Reply side: check every accepted item and stall in random bursts.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_reply(m_tuser, m_tdata);
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (stall_on && $urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 9);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Ends the run when no channel has moved an item for too long.
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < WATCHDOG_CYCLES) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("%0t: watchdog expired with %0d replies outstanding", $time, sb.pending());
    $display("DONE: errors detected");
    $finish;
  end

  function automatic dhcp_msg_t make_msg(logic bcast, logic [31:0] ci, logic [31:0] gi,
                                         logic [31:0] xid, logic [31:0] yi,
                                         logic [7:0] mtype, logic [47:0] mac);
    dhcp_msg_t m;
    m.bcast = bcast;
    m.client_addr = ci;
    m.relay_addr = gi;
    m.xid = xid;
    m.your_addr = yi;
    m.mtype = mtype;
    m.mac = mac;
    return m;
  endfunction

  // Mostly well-formed DISCOVER/REQUEST exchanges with random content, the
  // rest broken exchanges and plain noise.
  function automatic dhcp_msg_t random_msg(int unsigned disc_pct);
    dhcp_msg_t m;
    int unsigned pick;
    m.bcast = 1'($urandom);
    m.client_addr = $urandom;
    m.relay_addr = $urandom;
    m.xid = $urandom;
    m.your_addr = $urandom;
    m.mtype = 8'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 8) : $urandom);
    m.mac = 48'({$urandom, $urandom});
    pick = $urandom_range(0, 99);
    if (pick < disc_pct + 45) begin
      // Start from a well-formed message of either kind.
      m.bcast = 1'b1;
      if (pick < disc_pct || (pick >= disc_pct + 30 && pick[0])) begin
        m.client_addr = '0;
        m.relay_addr = '0;
        m.mtype = MSG_DISCOVER;
        if (m.xid == sb.xid_seen) m.xid = ~m.xid;
      end else begin
        m.xid = sb.xid_seen;
        m.mtype = MSG_REQUEST;
        if ($urandom_range(0, 3) != 0) m.your_addr = sb.last_offer;
      end
      // Then break one condition of it.
      if (pick >= disc_pct + 30) begin
        case ($urandom_range(0, 4))
          0: m.bcast = 1'b0;
          1: m.client_addr = m.client_addr | (32'd1 << $urandom_range(0, 31));
          2: m.relay_addr = m.relay_addr | (32'd1 << $urandom_range(0, 31));
          3: m.xid = sb.xid_seen;
          default: m.xid = sb.xid_seen ^ (32'd1 << $urandom_range(0, 31));
        endcase
      end
    end
    return m;
  endfunction

  task automatic send_msg(dhcp_msg_t m);
    if (stall_on && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {7'd0, m.mac, m.your_addr, m.xid, m.relay_addr, m.client_addr, m.bcast};
    s_tuser <= m.mtype;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_message(m);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.note_config(idx, value);
  endtask

  // Stop sending and hold off until every reply has come back.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned disc_pct;
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part with the reset configuration.
    // A REQUEST with id zero is acknowledged right after reset.
    send_msg(make_msg(1'b1, '0, '0, '0, '1, MSG_REQUEST, '1));
    // A DISCOVER reusing the remembered id gets a reply of kind none.
    send_msg(make_msg(1'b1, '0, '0, '0, '0, MSG_DISCOVER, 48'h0123_4567_89AB));
    send_msg(make_msg(1'b1, '0, '0, '1, '0, MSG_DISCOVER, '0));
    send_msg(make_msg(1'b1, '0, '0, '1, sb.last_offer, MSG_REQUEST, 48'hA5A5_5A5A_C3C3));
    send_msg(make_msg(1'b1, '0, '0, 32'hFFFF_FFFE, sb.last_offer, MSG_REQUEST, '1));
    // Broadcast, client and relay conditions of a DISCOVER broken one at a time, then a REQUEST without broadcast.
    send_msg(make_msg(1'b0, '0, '0, 32'h1234_5678, '0, MSG_DISCOVER, '1));
    send_msg(make_msg(1'b1, 32'h8000_0000, '0, 32'h1234_5678, '0, MSG_DISCOVER, '1));
    send_msg(make_msg(1'b1, '0, 32'h0000_0001, 32'h1234_5678, '0, MSG_DISCOVER, '1));
    send_msg(make_msg(1'b0, '0, '0, '1, '1, MSG_REQUEST, '1));
    // Option absent and other message types.
    send_msg(make_msg(1'b1, '0, '0, 32'h0BAD_F00D, '0, MSG_ABSENT, '1));
    send_msg(make_msg(1'b1, '0, '0, '1, '1, MSG_TYPE_MAX, '1));
    send_msg(make_msg(1'b1, '0, '0, '1, '1, MSG_OFFER, '1));
    send_msg(make_msg(1'b1, '0, '0, 32'd1, '0, MSG_DISCOVER, '1));
    // A REQUEST does not look at the client and relay addresses.
    send_msg(make_msg(1'b1, '1, '1, 32'd1, sb.last_offer, MSG_REQUEST, '0));
    send_msg(make_msg(1'b0, '0, '0, '0, '0, MSG_ABSENT, '0));
    send_msg(make_msg(1'b1, '1, '1, '1, '1, MSG_TYPE_MAX, '1));
    drain();

    // Random phases, each under its own register settings.
    for (int ph = 1; ph <= PHASES; ph++) begin
      case (ph)
        1: begin
          write_reg(REG_POOL_PREFIX, 32'hFFFF_FFFF);
          write_reg(REG_SERVER_ADDR, 32'hFFFF_FFFF);
          write_reg(REG_UNMAPPED, $urandom);
          write_reg(REG_TOP_IDX, 32'h0000_0000);
        end
        2: begin
          // Bits above the prefix width are dropped.
          write_reg(REG_POOL_PREFIX, 32'h5A00_0000);
          write_reg(REG_SERVER_ADDR, 32'h0000_0000);
        end
        3: begin
          write_reg(REG_POOL_PREFIX, $urandom);
          write_reg(REG_SERVER_ADDR, $urandom);
          write_reg(REG_TOP_IDX, 32'hFFFF_FFFF);
        end
        default: begin
          write_reg(REG_POOL_PREFIX, {8'h00, PREFIX_RESET});
          write_reg(REG_SERVER_ADDR, $urandom);
        end
      endcase
      cfg_valid <= 1'b0;
      // The last phase runs without idling and leans on DISCOVER so the pool
      // runs dry.
      stall_on = (ph < PHASES);
      disc_pct = (ph < PHASES) ? 40 : 60;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_msg(random_msg(disc_pct));
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
